// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// clocked assertion helpers shared by the rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// assertion on clk_i, off while rst_ni is low
`define SPG_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// assertion on clk_i that is also checked during reset
`define SPG_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== rtl/spg_pkg.sv =====
// ----------------------------------------------------------------------------
// spg_pkg
// types and constants of the step/direction pulse generator
// ----------------------------------------------------------------------------
package spg_pkg;

  localparam int unsigned PosBits = 32;
  localparam int unsigned TmrBits = 16;
  localparam int unsigned AngBits = 16;
  localparam int unsigned CfgIdxBits = 2;
  localparam int unsigned CfgDataBits = 32;

  typedef enum logic [2:0] {
    OP_TICK     = 3'd0,
    OP_MOVE_BY  = 3'd1,
    OP_MOVE_TO  = 3'd2,
    OP_PULSE    = 3'd3,
    OP_SET_ZERO = 3'd4
  } op_e;

  typedef enum logic [CfgIdxBits-1:0] {
    CFG_LIMITS_EN  = 2'd0,
    CFG_MIN_LIMIT  = 2'd1,
    CFG_MAX_LIMIT  = 2'd2,
    CFG_STEP_ANGLE = 2'd3
  } cfg_idx_e;

  localparam logic [PosBits-1:0] MinLimitRst  = 32'h8000_0000;
  localparam logic [PosBits-1:0] MaxLimitRst  = 32'h7FFF_FFFF;
  localparam logic [AngBits-1:0] StepAngleRst = 16'd461;

  typedef struct packed {
    logic               limits_en;
    logic [PosBits-1:0] min_limit;
    logic [PosBits-1:0] max_limit;
    logic [AngBits-1:0] step_angle;
  } cfg_t;

  typedef struct packed {
    logic [2:0]         operation;
    logic [PosBits-1:0] amount;
    logic [TmrBits-1:0] half_period;
    logic               direction;
  } item_t;

  typedef struct packed {
    logic               step_level;
    logic               dir_level;
    logic [PosBits-1:0] position;
    logic               busy_res;
    logic               rejected;
  } result_t;

endpackage

// ===== rtl/spg_core.sv =====
// ----------------------------------------------------------------------------
// spg_core
// motion state registers and the per-item next-state logic
// ----------------------------------------------------------------------------
module spg_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  spg_pkg::item_t   item_i,
  input  spg_pkg::cfg_t    cfg_i,
  output spg_pkg::result_t res_o
);

  logic [spg_pkg::PosBits-1:0] pos_q, pos_d;
  logic [spg_pkg::PosBits-1:0] rem_q, rem_d;
  logic [spg_pkg::TmrBits-1:0] tmr_q, tmr_d;
  logic [spg_pkg::TmrBits-1:0] hold_q, hold_d;
  logic step_q, step_d;
  logic dir_q, dir_d;
  logic active_q, active_d;
  logic track_q, track_d;

  logic                        rej;
  logic [2:0]                  op;
  logic signed [33:0]          pos_x, lo_x, hi_x, amt_x, sa_x;
  logic signed [33:0]          t_x, d_x, mv_a, a_x;
  logic signed [35:0]          tgt_x;
  logic                        mt_dir, mv_dir, mv_go;
  logic [spg_pkg::TmrBits-1:0] tmr_dec;
  logic [spg_pkg::PosBits-1:0] sa_w, rem_sub;

  always_comb begin
    pos_x = $signed({{2{pos_q[31]}}, pos_q});
    lo_x  = $signed({{2{cfg_i.min_limit[31]}}, cfg_i.min_limit});
    hi_x  = $signed({{2{cfg_i.max_limit[31]}}, cfg_i.max_limit});
    amt_x = $signed({{2{item_i.amount[31]}}, item_i.amount});
    sa_x  = $signed({18'b0, cfg_i.step_angle});
    sa_w  = {16'b0, cfg_i.step_angle};

    // absolute target, clamped to the limits, turned into a distance
    t_x    = amt_x;
    mt_dir = item_i.direction;
    if (cfg_i.limits_en) begin
      if (t_x > hi_x) begin
        t_x    = hi_x;
        mt_dir = 1'b1;
      end else if (t_x < lo_x) begin
        t_x    = lo_x;
        mt_dir = 1'b0;
      end
    end
    d_x = t_x - pos_x;
    if (d_x < 0) begin
      d_x = -d_x;
    end

    if (item_i.operation == 3'(spg_pkg::OP_MOVE_TO)) begin
      mv_a   = d_x;
      mv_dir = mt_dir;
    end else begin
      mv_a   = amt_x;
      mv_dir = item_i.direction;
    end

    // relative clamp, applied once
    a_x   = mv_a;
    tgt_x = mv_dir ? 36'(pos_x) + 36'(mv_a) : 36'(pos_x) - 36'(mv_a);
    if (cfg_i.limits_en) begin
      if (tgt_x > 36'(hi_x)) begin
        a_x = hi_x - pos_x;
      end else if (tgt_x < 36'(lo_x)) begin
        a_x = pos_x - lo_x;
      end
    end
    mv_go = (mv_a > 0) && (a_x > 0) && (cfg_i.step_angle != '0) && (a_x >= sa_x);

    tmr_dec = (tmr_q != '0) ? tmr_q - 1'b1 : '0;
    rem_sub = (rem_q >= sa_w) ? rem_q - sa_w : '0;

    pos_d    = pos_q;
    rem_d    = rem_q;
    tmr_d    = tmr_q;
    hold_d   = hold_q;
    step_d   = step_q;
    dir_d    = dir_q;
    active_d = active_q;
    track_d  = track_q;

    rej = active_q && (item_i.operation >= 3'(spg_pkg::OP_MOVE_BY))
          && (item_i.operation <= 3'(spg_pkg::OP_SET_ZERO));
    op  = rej ? 3'(spg_pkg::OP_TICK) : item_i.operation;

    case (op)
      spg_pkg::OP_MOVE_BY, spg_pkg::OP_MOVE_TO: begin
        dir_d = mv_dir;
        if (mv_go) begin
          rem_d    = a_x[31:0];
          track_d  = 1'b1;
          step_d   = 1'b1;
          tmr_d    = item_i.half_period;
          hold_d   = item_i.half_period;
          active_d = 1'b1;
        end
      end
      spg_pkg::OP_PULSE: begin
        dir_d    = item_i.direction;
        track_d  = 1'b0;
        rem_d    = '0;
        step_d   = 1'b1;
        tmr_d    = item_i.half_period >> 1;
        hold_d   = item_i.half_period >> 1;
        active_d = 1'b1;
      end
      spg_pkg::OP_SET_ZERO: begin
        pos_d = '0;
      end
      default: begin
        if (active_q) begin
          tmr_d = tmr_dec;
          if (tmr_dec == '0) begin
            if (step_q) begin
              // high half done, start the low half
              step_d = 1'b0;
              tmr_d  = hold_q;
            end else if (track_q) begin
              pos_d = dir_q ? pos_q + sa_w : pos_q - sa_w;
              rem_d = rem_sub;
              if ((cfg_i.step_angle != '0) && (rem_sub >= sa_w)) begin
                step_d = 1'b1;
                tmr_d  = hold_q;
              end else begin
                active_d = 1'b0;
              end
            end else begin
              active_d = 1'b0;
            end
          end
        end
      end
    endcase

    res_o.step_level = step_d;
    res_o.dir_level  = dir_d;
    res_o.position   = pos_d;
    res_o.busy_res   = active_d;
    res_o.rejected   = rej;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      rem_q    <= '0;
      tmr_q    <= '0;
      hold_q   <= '0;
      step_q   <= 1'b0;
      dir_q    <= 1'b0;
      active_q <= 1'b0;
      track_q  <= 1'b0;
    end else if (en_i) begin
      pos_q    <= pos_d;
      rem_q    <= rem_d;
      tmr_q    <= tmr_d;
      hold_q   <= hold_d;
      step_q   <= step_d;
      dir_q    <= dir_d;
      active_q <= active_d;
      track_q  <= track_d;
    end
  end

endmodule

// ===== rtl/stepper_pulse_generator_soft_limits_top.sv =====
// ----------------------------------------------------------------------------
// stepper_pulse_generator_soft_limits_top
// step/direction pulse generator with tracked position and soft limits
// ----------------------------------------------------------------------------
// Each input item is one timer tick, optionally carrying a command (move by,
// move to, single pulse, set zero). Every item yields exactly one result
// item with the pin levels, position, busy flag and a rejected flag.
// Input channel: in_valid_i / in_stall_o, item taken when valid and not
// stall. Output channel: out_valid_o / out_stall_i, result taken likewise.
// The item is registered in the input register; then the motion state is
// updated and the result registered. Throughput is one item per cycle while
// the receiver does not stall; the state update is a single pass of adds
// and compares through the core logic.
// If the receiver stalls, the result register holds its item and one more
// item waits in the input register; only then does in_stall_o rise.
// Reset clears all motion state (position zero, pins low, idle) and loads
// the default configuration. Configuration is written through cfg_we_i,
// cfg_index_i and cfg_data_i; the user must write it only while the block is idle, which the block does not enforce.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module stepper_pulse_generator_soft_limits_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  operation_i,
  input  logic [31:0] amount_i,
  input  logic [15:0] half_period_i,
  input  logic        direction_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        step_level_o,
  output logic        dir_level_o,
  output logic [31:0] position_o,
  output logic        busy_res_o,
  output logic        rejected_o
);

  spg_pkg::cfg_t    cfg_q;
  spg_pkg::item_t   item_q;
  spg_pkg::result_t res_q, res_d;
  logic             in_vld_q;
  logic             out_vld_q;
  logic             adv;
  logic             in_acc;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.limits_en  <= 1'b0;
      cfg_q.min_limit  <= spg_pkg::MinLimitRst;
      cfg_q.max_limit  <= spg_pkg::MaxLimitRst;
      cfg_q.step_angle <= spg_pkg::StepAngleRst;
    end else if (cfg_we_i) begin
      unique case (spg_pkg::cfg_idx_e'(cfg_index_i))
        spg_pkg::CFG_LIMITS_EN:  cfg_q.limits_en  <= cfg_data_i[0];
        spg_pkg::CFG_MIN_LIMIT:  cfg_q.min_limit  <= cfg_data_i;
        spg_pkg::CFG_MAX_LIMIT:  cfg_q.max_limit  <= cfg_data_i;
        spg_pkg::CFG_STEP_ANGLE: cfg_q.step_angle <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // item moves into the core when the result register is free
  assign adv        = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && out_vld_q && out_stall_i;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_acc) begin
        in_vld_q <= 1'b1;
      end else if (adv) begin
        in_vld_q <= 1'b0;
      end
      if (adv) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      item_q.operation   <= operation_i;
      item_q.amount      <= amount_i;
      item_q.half_period <= half_period_i;
      item_q.direction   <= direction_i;
    end
    if (adv) begin
      res_q <= res_d;
    end
  end

  spg_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .item_i (item_q),
    .cfg_i  (cfg_q),
    .res_o  (res_d)
  );

  assign out_valid_o  = out_vld_q;
  assign step_level_o = res_q.step_level;
  assign dir_level_o  = res_q.dir_level;
  assign position_o   = res_q.position;
  assign busy_res_o   = res_q.busy_res;
  assign rejected_o   = res_q.rejected;

  `SPG_ASSERT(a_idle_pin_low, out_valid_o && !busy_res_o |-> !step_level_o, "step pin high while idle")
  `SPG_ASSERT_ALWAYS(a_stall_only_full, in_stall_o |-> out_valid_o && out_stall_i, "input stalled with free result slot")
  `SPG_ASSERT(a_accept_holds, in_acc |=> in_vld_q, "accepted item lost")

endmodule

// ===== dv/stepper_pulse_generator_soft_limits_top_tb.sv =====
// ----------------------------------------------------------------------------
// stepper_pulse_generator_soft_limits_top_tb
// self-checking bench for the step/direction pulse generator
// ----------------------------------------------------------------------------
// Sends ticks and motion commands through the valid/stall input channel and
// compares every result item with a tick-level model of the step timer,
// position tracking and soft limits. Register settings change between
// phases once the pipeline is empty. Both channels idle and stall at random,
// the receiver holds off for long stretches, and long moves are cut short by
// clearing the step angle.
// ----------------------------------------------------------------------------
module stepper_pulse_generator_soft_limits_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import spg_pkg::*;

  localparam int unsigned ItemTarget = 1250;
  localparam int unsigned TickBudget = 100;
  localparam int unsigned HoldCycles = 200;
  localparam logic [2:0]  OpUnusedLo = 3'd5;
  localparam logic [2:0]  OpUnusedHi = 3'd7;

  class motion_checker;
    bit        limits_en;
    bit [31:0] min_lim, max_lim;
    bit [15:0] step_ang;
    bit [31:0] pos, remaining;
    bit [15:0] timer, hold;
    bit        step_pin, dir_pin, active, track;
    result_t   pending_results[$];
    int unsigned n_items, n_checked, n_errors, n_rejected, n_steps;

    function new();
      limits_en = 1'b0;
      min_lim   = MinLimitRst;
      max_lim   = MaxLimitRst;
      step_ang  = StepAngleRst;
      pos       = '0;
      remaining = '0;
      timer     = '0;
      hold      = '0;
      step_pin  = 1'b0;
      dir_pin   = 1'b0;
      active    = 1'b0;
      track     = 1'b0;
    endfunction

    function void write_cfg(cfg_idx_e idx, bit [31:0] data);
      case (idx)
        CFG_LIMITS_EN:  limits_en = data[0];
        CFG_MIN_LIMIT:  min_lim = data;
        CFG_MAX_LIMIT:  max_lim = data;
        CFG_STEP_ANGLE: step_ang = data[15:0];
        default: ;
      endcase
    endfunction

    function void start_step(bit [15:0] half);
      step_pin = 1'b1;
      timer    = half;
      hold     = half;
      active   = 1'b1;
    endfunction

    function void move_relative(longint a, bit dir, bit [15:0] half);
      longint p, tgt, lo, hi;
      p  = longint'($signed(pos));
      lo = longint'($signed(min_lim));
      hi = longint'($signed(max_lim));
      dir_pin = dir;
      if (a <= 0) return;
      // clamp once against whichever limit the target crosses
      if (limits_en) begin
        tgt = dir ? p + a : p - a;
        if (tgt > hi) a = hi - p;
        else if (tgt < lo) a = p - lo;
      end
      if (a <= 0 || step_ang == 0 || a < longint'(step_ang)) return;
      remaining = (a > 64'sh0_FFFF_FFFF) ? 32'hFFFF_FFFF : a[31:0];
      track = 1'b1;
      start_step(half);
    endfunction

    function void move_absolute(longint t, bit dir, bit [15:0] half);
      longint d, lo, hi;
      lo = longint'($signed(min_lim));
      hi = longint'($signed(max_lim));
      // an out-of-range target forces the direction, otherwise it is kept
      if (limits_en) begin
        if (t > hi) begin
          t = hi;
          dir = 1'b1;
        end else if (t < lo) begin
          t = lo;
          dir = 1'b0;
        end
      end
      d = t - longint'($signed(pos));
      if (d < 0) d = -d;
      move_relative(d, dir, half);
    endfunction

    function void advance_tick();
      if (!active) return;
      if (timer != 0) timer--;
      if (timer != 0) return;
      if (step_pin) begin
        step_pin = 1'b0;
        timer = hold;
        return;
      end
      if (track) begin
        pos = dir_pin ? pos + 32'(step_ang) : pos - 32'(step_ang);
        remaining = (remaining >= 32'(step_ang)) ? remaining - 32'(step_ang) : '0;
        n_steps++;
        if (step_ang != 0 && remaining >= 32'(step_ang)) begin
          step_pin = 1'b1;
          timer = hold;
          return;
        end
      end
      active = 1'b0;
    endfunction

    function void accept_item(logic [2:0] op, bit [31:0] amount, bit [15:0] half, bit dir);
      bit rej;
      rej = 1'b0;
      n_items++;
      if (op >= OP_MOVE_BY && op <= OP_SET_ZERO && active) begin
        rej = 1'b1;
        n_rejected++;
        op = OP_TICK;
      end
      case (op)
        OP_MOVE_BY: move_relative(longint'($signed(amount)), dir, half);
        OP_MOVE_TO: move_absolute(longint'($signed(amount)), dir, half);
        OP_PULSE: begin
          dir_pin = dir;
          track = 1'b0;
          remaining = '0;
          start_step(half >> 1);
        end
        OP_SET_ZERO: pos = '0;
        default: advance_tick();
      endcase
      pending_results.push_back('{step_level: step_pin, dir_level: dir_pin, position: pos,
                                  busy_res: active, rejected: rej});
    endfunction

    task report(string msg);
      n_errors++;
      if (n_errors <= 30) $display("mismatch at %0t: %s", $time, msg);
    endtask

    task check_result(result_t got);
      result_t want;
      if (pending_results.size() == 0) begin
        report($sformatf("result item with nothing expected, position %h", got.position));
        return;
      end
      want = pending_results.pop_front();
      n_checked++;
      if (got.step_level !== want.step_level)
        report($sformatf("result %0d step_level %b, expected %b", n_checked,
                         got.step_level, want.step_level));
      if (got.dir_level !== want.dir_level)
        report($sformatf("result %0d dir_level %b, expected %b", n_checked,
                         got.dir_level, want.dir_level));
      if (got.position !== want.position)
        report($sformatf("result %0d position %h, expected %h", n_checked,
                         got.position, want.position));
      if (got.busy_res !== want.busy_res)
        report($sformatf("result %0d busy_res %b, expected %b", n_checked,
                         got.busy_res, want.busy_res));
      if (got.rejected !== want.rejected)
        report($sformatf("result %0d rejected %b, expected %b", n_checked,
                         got.rejected, want.rejected));
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [2:0]  operation_i = '0;
  logic [31:0] amount_i = '0;
  logic [15:0] half_period_i = '0;
  logic        direction_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        step_level_o;
  logic        dir_level_o;
  logic [31:0] position_o;
  logic        busy_res_o;
  logic        rejected_o;

  motion_checker motion;
  bit            idle_en = 1'b1;
  bit            hold_req = 1'b0;
  int unsigned   n_holdoffs = 0;
  int unsigned   n_settings = 0;

  stepper_pulse_generator_soft_limits_top uut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  initial begin
    #10ms;
    $display("Mismatches found");
    $finish;
  end

  // result side: check, then pick the stall level for the next cycle
  initial begin : result_sink
    int unsigned hold_left;
    result_t     got;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o === 1'b1 && out_stall_i == 1'b0) begin
        got = '{step_level_o, dir_level_o, position_o, busy_res_o, rejected_o};
        motion.check_result(got);
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (hold_req) begin
        hold_req = 1'b0;
        n_holdoffs++;
        hold_left = HoldCycles - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= idle_en && ($urandom_range(99) < 22);
      end
    end
  end

  task automatic send_item(logic [2:0] op, bit [31:0] amount, bit [15:0] half, bit dir);
    if (idle_en && $urandom_range(99) < 22) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    operation_i   <= op;
    amount_i      <= amount;
    half_period_i <= half;
    direction_i   <= dir;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    motion.accept_item(op, amount, half, dir);
  endtask

  task automatic send_tick();
    send_item(OP_TICK, $urandom, 16'($urandom), 1'($urandom));
  endtask

  task automatic drain_pipeline();
    in_valid_i <= 1'b0;
    while (motion.pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, bit [31:0] data, bit last = 1'b1);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    motion.write_cfg(idx, data);
    if (last) cfg_we_i <= 1'b0;
  endtask

  task automatic apply_setting(bit lim, bit [31:0] lo, bit [31:0] hi, bit [15:0] ang);
    drain_pipeline();
    write_reg(CFG_LIMITS_EN, 32'(lim), 1'b0);
    write_reg(CFG_MIN_LIMIT, lo, 1'b0);
    write_reg(CFG_MAX_LIMIT, hi, 1'b0);
    write_reg(CFG_STEP_ANGLE, 32'(ang));
    n_settings++;
  endtask

  // tick until the motor stops; commands sent meanwhile are rejected.
  // a move that runs too long is stopped by clearing the step angle
  task automatic run_to_idle();
    int unsigned n;
    bit          cut;
    bit [15:0]   saved;
    n = 0;
    cut = 1'b0;
    saved = '0;
    while (motion.active) begin
      if (n == TickBudget) begin
        cut = 1'b1;
        saved = motion.step_ang;
        drain_pipeline();
        write_reg(CFG_STEP_ANGLE, '0);
      end
      if ($urandom_range(99) < 6)
        send_item(3'($urandom_range(OP_MOVE_BY, OP_SET_ZERO)), $urandom, 16'($urandom),
                  1'($urandom));
      else
        send_tick();
      n++;
    end
    if (cut) begin
      drain_pipeline();
      write_reg(CFG_STEP_ANGLE, 32'(saved));
    end
  endtask

  function automatic bit [31:0] near_angle();
    bit [31:0] ang;
    ang = (motion.step_ang == 0) ? 32'd1000 : 32'(motion.step_ang);
    return ang * $urandom_range(0, 4) + $urandom_range(0, ang - 1);
  endfunction

  task automatic random_sequence();
    int unsigned pick;
    logic [2:0]  op;
    bit [31:0]   amt;
    bit [15:0]   half;
    bit          dir;
    pick = $urandom_range(99);
    dir  = 1'($urandom);
    half = ($urandom_range(3) == 0) ? 16'($urandom_range(4, 31)) : 16'($urandom_range(0, 3));
    amt  = near_angle();
    if (pick < 40) begin
      op = OP_MOVE_BY;
      if (pick < 4) amt = -amt;
      else if (pick < 6) amt = $urandom;
    end else if (pick < 62) begin
      op = OP_MOVE_TO;
      if (pick < 58) amt = $urandom_range(1) ? motion.pos + amt : motion.pos - amt;
      else amt = $urandom;
    end else if (pick < 76) begin
      op = OP_PULSE;
    end else if (pick < 84) begin
      op = OP_SET_ZERO;
    end else if (pick < 90) begin
      op = 3'($urandom_range(OpUnusedLo, OpUnusedHi));
    end else begin
      // any code with any fields, short periods only
      op   = 3'($urandom_range(OP_TICK, OpUnusedHi));
      amt  = $urandom;
      half = 16'($urandom_range(0, 15));
    end
    send_item(op, amt, half, dir);
    if ($urandom_range(3) == 0) send_tick();
    run_to_idle();
  endtask

  task automatic random_phase(int unsigned n_end);
    while (motion.n_items < n_end) random_sequence();
  endtask

  task automatic directed_checks();
    apply_setting(1'b0, MinLimitRst, MaxLimitRst, StepAngleRst);
    send_item(OP_TICK, 32'h8000_0000, 16'hFFFF, 1'b1);
    send_item(OP_TICK, 32'h7FFF_FFFF, 16'h0000, 1'b0);
    // zero half period behaves like one tick per half
    send_item(OP_MOVE_BY, 2 * StepAngleRst + 5, 16'd0, 1'b1);
    run_to_idle();
    // commands while busy are ignored
    send_item(OP_MOVE_BY, 3 * StepAngleRst, 16'd1, 1'b0);
    send_item(OP_PULSE, 32'd0, 16'd4, 1'b1);
    send_item(OP_SET_ZERO, 32'd0, 16'd0, 1'b0);
    run_to_idle();
    // zero, negative and sub-step moves only set the direction pin
    send_item(OP_MOVE_BY, 32'd0, 16'd0, 1'b1);
    send_item(OP_MOVE_BY, 32'h8000_0000, 16'd0, 1'b0);
    send_item(OP_MOVE_BY, StepAngleRst - 1, 16'd0, 1'b1);
    send_item(OP_PULSE, 32'd0, 16'd5, 1'b1);
    run_to_idle();
    send_item(OP_PULSE, 32'd0, 16'd1, 1'b0);
    run_to_idle();
    send_item(OpUnusedLo, 32'hFFFF_FFFF, 16'hFFFF, 1'b1);
    send_item(OpUnusedHi, 32'd0, 16'd0, 1'b0);
    // absolute move keeps the given direction even away from the target
    send_item(OP_MOVE_TO, 3 * StepAngleRst, 16'd0, 1'b0);
    run_to_idle();
    send_item(OP_SET_ZERO, 32'd0, 16'd0, 1'b0);
    send_item(OP_MOVE_BY, StepAngleRst, 16'd40, 1'b1);
    run_to_idle();

    // soft limits on both sides, relative and absolute
    apply_setting(1'b1, -32'sd1000, 32'sd1000, StepAngleRst);
    send_item(OP_MOVE_BY, 32'd5000, 16'd0, 1'b1);
    run_to_idle();
    send_item(OP_MOVE_BY, 32'd5000, 16'd0, 1'b0);
    run_to_idle();
    send_item(OP_MOVE_TO, 32'h7FFF_FFFF, 16'd0, 1'b0);
    run_to_idle();
    send_item(OP_MOVE_TO, 32'h8000_0000, 16'd0, 1'b1);
    run_to_idle();

    // zero step angle: no steps at all
    apply_setting(1'b0, MinLimitRst, MaxLimitRst, 16'd0);
    send_item(OP_MOVE_BY, 32'd2000, 16'd0, 1'b1);
    drain_pipeline();
    write_reg(CFG_STEP_ANGLE, 32'(StepAngleRst));

    // step angle cleared, then raised, while a move runs
    send_item(OP_MOVE_BY, 4 * StepAngleRst, 16'd2, 1'b1);
    repeat (3) send_tick();
    drain_pipeline();
    write_reg(CFG_STEP_ANGLE, '0);
    run_to_idle();
    drain_pipeline();
    write_reg(CFG_STEP_ANGLE, 32'(StepAngleRst));
    send_item(OP_MOVE_BY, 4 * StepAngleRst, 16'd2, 1'b0);
    repeat (3) send_tick();
    drain_pipeline();
    write_reg(CFG_STEP_ANGLE, 32'd2000);
    run_to_idle();
  endtask

  initial begin : stimulus
    int unsigned share;
    motion = new();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    directed_checks();
    share = ItemTarget / 7;

    apply_setting(1'b0, MinLimitRst, MaxLimitRst, StepAngleRst);
    random_phase(motion.n_items + share);

    // no idling on either side
    idle_en = 1'b0;
    apply_setting(1'b1, motion.pos - 32'd3000, motion.pos + 32'd3000, StepAngleRst);
    random_phase(motion.n_items + share);
    idle_en = 1'b1;

    apply_setting(1'b1, motion.pos - $urandom_range(0, 8000), motion.pos + $urandom_range(0, 8000),
                  16'($urandom_range(1, 2000)));
    hold_req = 1'b1;
    random_phase(motion.n_items + share);

    apply_setting(1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 16'hFFFF);
    random_phase(motion.n_items + share);

    apply_setting(1'b0, MinLimitRst, MaxLimitRst, 16'd1);
    hold_req = 1'b1;
    random_phase(motion.n_items + share);

    // inverted window, min above max
    apply_setting(1'b1, motion.pos + 32'd1000, motion.pos - 32'd1000, 16'd300);
    random_phase(motion.n_items + share);

    apply_setting(1'b1, motion.pos - $urandom_range(0, 20000),
                  motion.pos + $urandom_range(0, 20000), 16'($urandom_range(1, 65535)));
    random_phase(motion.n_items + share);

    drain_pipeline();
    repeat (8) @(posedge clk_i);
    $display("run covered %0d items over %0d register settings, %0d results checked",
             motion.n_items, n_settings, motion.n_checked);
    $display("%0d commands rejected while busy, %0d motor steps, %0d receiver hold-offs",
             motion.n_rejected, motion.n_steps, n_holdoffs);
    if (motion.n_errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/spg_pkg.sv
rtl/spg_core.sv
rtl/stepper_pulse_generator_soft_limits_top.sv
dv/stepper_pulse_generator_soft_limits_top_tb.sv
